### rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros: shared concurrent assertion helpers
// Clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge
`define ASSERT_PROP(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// antecedent at one edge implies consequent at the next
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/oit_pkg.sv
// ---------------------------------------------------------------------------
// oit_pkg: shared types for the ordered insert table
// Beat structs, command and status codes, cell control.
// ---------------------------------------------------------------------------
package oit_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int VALUE_W      = 32;
  localparam int INDEX_W      = 7;
  localparam int FOUND_W      = 6;

  typedef enum logic [1:0] {
    CMD_READ   = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_INSERT = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_OUT_OF_BOUNDS = 3'd1,
    ST_FOUND         = 3'd2,
    ST_NOT_FOUND     = 3'd3,
    ST_FULL          = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_ROTATE
  } cell_op_t;

  typedef struct packed {
    logic [1:0]                command;
    logic [INDEX_W-1:0]        index;
    logic signed [VALUE_W-1:0] value;
  } in_beat_t;

  typedef struct packed {
    status_t                   status;
    logic signed [VALUE_W-1:0] read_value;
    logic [FOUND_W-1:0]        found_index;
  } out_beat_t;

  typedef struct packed {
    cell_op_t           op;
    logic [VALUE_W-1:0] value;
  } cell_ctl_t;

endpackage

### rtl/core/oit_cell.sv
// ---------------------------------------------------------------------------
// oit_cell: one entry of the table row
// Holds a word; shifts up on insert, rotates toward the head on scan.
// ---------------------------------------------------------------------------
module oit_cell #(
  parameter int CAPACITY = oit_pkg::CAPACITY_DEF,
  parameter int POS      = 0,
  localparam int CW      = $clog2(CAPACITY + 1)
) (
  input  logic                         clk,
  input  oit_pkg::cell_ctl_t           ctl,
  input  logic [CW-1:0]                ins_pos,
  input  logic [CW-1:0]                count,
  input  logic [oit_pkg::VALUE_W-1:0]  left_data,
  input  logic [oit_pkg::VALUE_W-1:0]  right_data,
  input  logic [oit_pkg::VALUE_W-1:0]  head_data,
  output logic [oit_pkg::VALUE_W-1:0]  data_o
);
  import oit_pkg::*;

  localparam logic [CW-1:0] MY_POS = CW'(POS);

  logic [VALUE_W-1:0] data_r, data_nxt;

  always_comb begin
    data_nxt = data_r;
    case (ctl.op)
      CELL_HOLD: ;
      CELL_INSERT: begin
        if (MY_POS == ins_pos) begin
          data_nxt = ctl.value;
        end else if (MY_POS > ins_pos) begin
          data_nxt = left_data;
        end
      end
      CELL_ROTATE: begin
        // live ring is positions 0..count-1; tail wraps to the head word
        if (MY_POS < count) begin
          data_nxt = (MY_POS == count - CW'(1)) ? head_data : right_data;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;

endmodule

### rtl/core/ordered_insert_table.sv
// ---------------------------------------------------------------------------
// ordered_insert_table: fixed-capacity ordered word table on a row of cells
// Insert, full, out-of-range, unused and empty-table commands: result registered on accept,
// or held in S_DONE while stalled. Read and search: the live cells rotate one place per
// cycle past the head. Next beat accepted once the result is in the output register. Sync
// active-low reset clears the count and control; cell words stay undefined until written.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ordered_insert_table #(
  parameter int CAPACITY = oit_pkg::CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  oit_pkg::in_beat_t  in_beat,
  output logic               out_valid,
  input  logic               out_stall,
  output oit_pkg::out_beat_t out_beat
);
  import oit_pkg::*;

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > INDEX_W) ? CW : INDEX_W;
  localparam int FW   = (CW > FOUND_W) ? CW : FOUND_W;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      step_r, step_nxt;
  logic               is_read_r, is_read_nxt;
  logic [CMPW-1:0]    idx_r, idx_nxt;
  logic [VALUE_W-1:0] key_r, key_nxt;
  out_beat_t          res_r, res_nxt;
  logic               out_valid_r;
  out_beat_t          out_beat_r;

  logic               acc, slot_free, fin, immediate, start, last_step;
  logic [CMPW-1:0]    idx_w, cnt_w;
  logic [FW-1:0]      step_f;
  out_beat_t          fin_beat, scan_beat;
  cell_ctl_t          ctl;
  logic [VALUE_W-1:0] cell_data [CAPACITY];
  logic [VALUE_W-1:0] head;

  assign acc       = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign idx_w     = CMPW'(in_beat.index);
  assign cnt_w     = CMPW'(count_r);
  assign last_step = (step_r == count_r - CW'(1));
  assign step_f    = FW'(step_r);
  assign head      = cell_data[0];

  // scan update: head holds the element at position step_r
  always_comb begin
    scan_beat = res_r;
    if (is_read_r) begin
      if (CMPW'(step_r) == idx_r) begin
        scan_beat.read_value = $signed(head);
      end
    end else if (res_r.status == ST_NOT_FOUND && head == key_r) begin
      scan_beat.status      = ST_FOUND;
      scan_beat.found_index = step_f[FOUND_W-1:0];
    end
  end

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    step_nxt    = step_r;
    is_read_nxt = is_read_r;
    idx_nxt     = idx_r;
    key_nxt     = key_r;
    res_nxt     = res_r;
    fin         = 1'b0;
    immediate   = 1'b0;
    start       = 1'b0;
    fin_beat    = res_r;
    ctl.op      = CELL_HOLD;
    ctl.value   = in_beat.value;

    case (state_r)
      S_IDLE: begin
        if (acc) begin
          immediate = 1'b1;
          fin_beat  = '{status: ST_OUT_OF_BOUNDS, read_value: '0, found_index: '0};
          case (in_beat.command)
            CMD_READ: begin
              if (idx_w < cnt_w) begin
                immediate   = 1'b0;
                start       = 1'b1;
                is_read_nxt = 1'b1;
                res_nxt     = '{status: ST_OK, read_value: '0, found_index: '0};
              end
            end
            CMD_SEARCH: begin
              if (count_r != '0) begin
                immediate   = 1'b0;
                start       = 1'b1;
                is_read_nxt = 1'b0;
                res_nxt     = '{status: ST_NOT_FOUND, read_value: '0, found_index: '0};
              end else begin
                fin_beat.status = ST_NOT_FOUND;
              end
            end
            CMD_INSERT: begin
              // bounds check ranks above the full check
              if (idx_w > cnt_w) begin
                fin_beat.status = ST_OUT_OF_BOUNDS;
              end else if (count_r == CW'(CAPACITY)) begin
                fin_beat.status = ST_FULL;
              end else begin
                ctl.op          = CELL_INSERT;
                count_nxt       = count_r + CW'(1);
                fin_beat.status = ST_OK;
              end
            end
            default: ;
          endcase
          if (start) begin
            state_nxt = S_SCAN;
            step_nxt  = '0;
            idx_nxt   = idx_w;
            key_nxt   = in_beat.value;
          end
          if (immediate) begin
            if (slot_free) begin
              fin = 1'b1;
            end else begin
              res_nxt   = fin_beat;
              state_nxt = S_DONE;
            end
          end
        end
      end
      S_SCAN: begin
        ctl.op   = CELL_ROTATE;
        step_nxt = step_r + CW'(1);
        res_nxt  = scan_beat;
        if (last_step) begin
          if (slot_free) begin
            fin       = 1'b1;
            fin_beat  = scan_beat;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (slot_free) begin
          fin       = 1'b1;
          fin_beat  = res_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (fin) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    step_r    <= step_nxt;
    is_read_r <= is_read_nxt;
    idx_r     <= idx_nxt;
    key_r     <= key_nxt;
    res_r     <= res_nxt;
    if (fin) begin
      out_beat_r <= fin_beat;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_W-1:0] left_d, right_d;
    if (i == 0) begin : g_first
      assign left_d = ctl.value;
    end else begin : g_mid_l
      assign left_d = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_d = head;
    end else begin : g_mid_r
      assign right_d = cell_data[i+1];
    end
    oit_cell #(
      .CAPACITY (CAPACITY),
      .POS      (i)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .ins_pos    (idx_w[CW-1:0]),
      .count      (count_r),
      .left_data  (left_d),
      .right_data (right_d),
      .head_data  (head),
      .data_o     (cell_data[i])
    );
  end

  `ASSERT_PROP(a_count_bound, count_r <= CW'(CAPACITY), "element count above capacity")
  `ASSERT_PROP(a_scan_step, (state_r == S_SCAN) |-> (step_r < count_r), "scan past live entries")
  `ASSERT_NEXT(a_count_hold, ctl.op != CELL_INSERT, count_r == $past(count_r), "count moved without insert")
  `ASSERT_NEXT(a_scan_result, state_r == S_SCAN && last_step && slot_free, out_valid_r, "scan result lost")

endmodule

### tb/sv/tb_ordered_insert_table.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_ordered_insert_table: self-checking bench for the ordered insert table
// A queue-fed driver sends read, search, insert and unused-command beats under
// random sender gaps and receiver stalls. A shadow table predicts each result,
// and the monitor checks every field in order.
// ---------------------------------------------------------------------------
module tb_ordered_insert_table;
  import oit_pkg::*;

  localparam int          CAP        = CAPACITY_DEF;
  localparam logic [1:0]  CMD_UNUSED = 2'd3;
  localparam int          RAND_ITEMS = 400;
  localparam int          LIMIT      = 500000;
  localparam int          DRAIN      = 2 * CAP + 20;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_beat = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_beat;

  ordered_insert_table #(.CAPACITY(CAP)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

  in_beat_t    pending_cmds[$];
  out_beat_t   expected_results[$];

  // shadow of the table contents
  logic [31:0] word_store[CAP];
  int          word_count = 0;

  // generator-side view, used to pick legal indices and known values and to tell when the table is full
  int          gen_count = 0;
  logic [31:0] gen_words[$];

  int          n_items = 0;
  int          sent = 0;
  int          errors = 0;
  int          cycles = 0;
  int          idle_pct = 36;
  int          stall_pct = 60;
  logic        in_taken = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic out_beat_t table_apply(in_beat_t b);
    out_beat_t r;
    int        i;
    logic      hit;
    r.status      = ST_OUT_OF_BOUNDS;
    r.read_value  = '0;
    r.found_index = '0;
    hit = 1'b0;
    case (b.command)
      CMD_READ: begin
        if (b.index < word_count) begin
          r.read_value = word_store[b.index];
          r.status     = ST_OK;
        end
      end
      CMD_SEARCH: begin
        r.status = ST_NOT_FOUND;
        for (i = 0; i < word_count && !hit; i++) begin
          if (word_store[i] == b.value) begin
            hit           = 1'b1;
            r.status      = ST_FOUND;
            r.found_index = i[FOUND_W-1:0];
          end
        end
      end
      CMD_INSERT: begin
        if (b.index > word_count) begin
          r.status = ST_OUT_OF_BOUNDS;
        end else if (word_count >= CAP) begin
          r.status = ST_FULL;
        end else begin
          for (i = word_count; i > b.index; i--) word_store[i] = word_store[i-1];
          word_store[b.index] = b.value;
          word_count++;
          r.status = ST_OK;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void push_item(logic [1:0] cmd, int idx, logic [31:0] val);
    in_beat_t b;
    b.command = cmd;
    b.index   = idx[INDEX_W-1:0];
    b.value   = val;
    pending_cmds.push_back(b);
    if (cmd == CMD_INSERT && idx <= gen_count && gen_count < CAP) begin
      gen_count++;
      gen_words.push_back(val);
    end
  endfunction

  function automatic logic [31:0] known_word();
    return gen_words[$urandom_range(gen_words.size() - 1)];
  endfunction

  // driver: new beat or gap on the falling edge, payload held while stalled
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      in_valid <= 1'b1;
    end else if (pending_cmds.size() != 0 && $urandom_range(99) >= idle_pct) begin
      in_beat  <= pending_cmds.pop_front();
      in_valid <= 1'b1;
    end else begin
      in_valid <= 1'b0;
    end
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  // input side: predict on accept, step the idle profile by progress
  always @(posedge clk) begin
    in_taken <= in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      expected_results.push_back(table_apply(in_beat));
      sent <= sent + 1;
      if (sent + 1 >= (2 * n_items) / 3) begin
        idle_pct  <= 0;
        stall_pct <= 0;
      end else if (sent + 1 >= n_items / 3) begin
        idle_pct  <= 60;
        stall_pct <= 36;
      end
    end
  end

  // monitor
  always @(posedge clk) begin : result_check
    out_beat_t exp_beat;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected: status %0d", out_beat.status);
        errors++;
      end else begin
        exp_beat = expected_results.pop_front();
        if (out_beat.status !== exp_beat.status) begin
          $error("status: expected %0d, got %0d", exp_beat.status, out_beat.status);
          errors++;
        end
        if (out_beat.read_value !== exp_beat.read_value) begin
          $error("read_value: expected %h, got %h", exp_beat.read_value,
                 out_beat.read_value);
          errors++;
        end
        if (out_beat.found_index !== exp_beat.found_index) begin
          $error("found_index: expected %0d, got %0d", exp_beat.found_index,
                 out_beat.found_index);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int          k;
    int          r;
    logic [31:0] v;

    // empty table, bound checks, extremes, first match among duplicates
    push_item(CMD_READ, 0, 32'h0);
    push_item(CMD_SEARCH, 0, 32'h0);
    push_item(CMD_INSERT, 1, 32'h5);
    push_item(CMD_INSERT, 0, 32'h8000_0000);
    push_item(CMD_INSERT, 1, 32'h7FFF_FFFF);
    push_item(CMD_INSERT, 0, 32'h0);
    push_item(CMD_INSERT, 1, 32'hFFFF_FFFF);
    push_item(CMD_INSERT, 2, 32'h7FFF_FFFF);
    push_item(CMD_READ, 0, 32'h0);
    push_item(CMD_READ, 4, 32'hFFFF_FFFF);
    push_item(CMD_READ, 5, 32'h0);
    push_item(CMD_READ, 127, 32'h0);
    push_item(CMD_SEARCH, 0, 32'h7FFF_FFFF);
    push_item(CMD_SEARCH, 0, 32'h0001_2345);
    push_item(CMD_SEARCH, 127, 32'h8000_0000);
    push_item(CMD_UNUSED, 0, 32'h0);
    push_item(CMD_UNUSED, 127, 32'hFFFF_FFFF);
    push_item(CMD_INSERT, 127, 32'h1);

    // mostly legal traffic with noise; keep going until the table fills
    k = 0;
    while (k < RAND_ITEMS || gen_count < CAP) begin
      r = $urandom_range(99);
      if (r < 35) begin
        v = (gen_words.size() != 0 && $urandom_range(4) == 0) ? known_word() : $urandom;
        push_item(CMD_INSERT, $urandom_range(gen_count), v);
      end else if (r < 60) begin
        push_item(CMD_READ, (gen_count > 0) ? $urandom_range(gen_count - 1) : 0, $urandom);
      end else if (r < 85) begin
        v = (gen_words.size() != 0 && $urandom_range(1) == 0) ? known_word() : $urandom;
        push_item(CMD_SEARCH, $urandom_range(127), v);
      end else begin
        push_item(2'($urandom_range(3)), $urandom_range(127), $urandom);
      end
      k++;
    end

    // full table: bound check wins over full
    push_item(CMD_INSERT, CAP, 32'hA5A5_A5A5);
    push_item(CMD_INSERT, CAP + 1, 32'h5A5A_5A5A);
    push_item(CMD_INSERT, 0, 32'h1);
    push_item(CMD_READ, CAP - 1, 32'h0);
    push_item(CMD_READ, CAP, 32'h0);
    push_item(CMD_SEARCH, 0, gen_words[CAP - 1]);
    n_items = pending_cmds.size();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (sent < n_items || expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
